// ----- sv/mahic_pkg.sv -----
// ----------------------------------------------------------------------------
// mahic_pkg
// Shared types and constants for the magnetometer window average and
// hard-iron offset calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

package mahic_pkg;

    localparam int RAW_W      = 16;
    localparam int FIELD_W    = 17;
    localparam int QUO_W      = 16;
    localparam int DEF_WINDOW = 10;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 104;

    localparam logic signed [RAW_W-1:0] CAL_MIN_START = 16'sd4096;
    localparam logic signed [RAW_W-1:0] CAL_MAX_START = -16'sd4096;

    typedef enum logic [1:0] {
        CMD_MEASURE   = 2'd0,
        CMD_CAL_BEGIN = 2'd1,
        CMD_CAL_SAMPLE = 2'd2,
        CMD_CAL_END   = 2'd3
    } cmd_t;

    // Stage load strobes and the command of the transaction being accepted.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        cmd_t cmd;
    } lane_ctl_t;

endpackage : mahic_pkg

`default_nettype wire

// ----- sv/magnetometer_average_hard_iron_cal.sv -----
// ----------------------------------------------------------------------------
// magnetometer_average_hard_iron_cal
// Three-axis window average with hard-iron offset calibration; one lane per
// axis, merged into a single result register.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit up)                       tuser
//  s_axis   in         raw_x, raw_y, raw_z                      cmd
//  m_axis   out        field_x..z, bias_x..z, zero pad          -
//
//  One transaction in each cycle while m_axis is not stalled; its accepting
//  edge loads the first of three register stages (update, registered
//  reciprocal multiply, output register).
//  Each lane keeps a running sum, so no stage walks the sample ring.
//  Reset clears the ring, sums, calibration state and all valid flags.
//  A stalled output holds its register; the pipeline fills before s_axis
//  tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_average_hard_iron_cal #(
    parameter int WINDOW = mahic_pkg::DEF_WINDOW
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [mahic_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // raw_x, raw_y, raw_z
    input  wire logic [mahic_pkg::IN_USER_W-1:0]     s_axis_tuser,  // cmd
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // field_x, field_y, field_z, bias_x, bias_y, bias_z, zero pad
    output logic [mahic_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    localparam int RAW_W   = mahic_pkg::RAW_W;
    localparam int FIELD_W = mahic_pkg::FIELD_W;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PACK_W  = 3 * FIELD_W + 3 * RAW_W;

    logic [SLOT_W-1:0] slot_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              out_valid_reg;
    logic [mahic_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic              accept;
    logic              adv1;
    logic              adv2;
    mahic_pkg::lane_ctl_t ctl;

    logic signed [RAW_W-1:0]   raw [3];
    logic signed [FIELD_W-1:0] field [3];
    logic signed [RAW_W-1:0]   bias [3];
    logic [PACK_W-1:0]         packed_res;

    assign adv2          = !out_valid_reg || m_axis_tready;
    assign adv1          = !v2_reg || adv2;
    assign s_axis_tready = !v1_reg || adv1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ctl.ld1 = accept;
    assign ctl.ld2 = v1_reg && adv1;
    assign ctl.ld3 = v2_reg && adv2;
    assign ctl.cmd = mahic_pkg::cmd_t'(s_axis_tuser);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && ctl.cmd == mahic_pkg::CMD_MEASURE)
            begin
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
            if (accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (ctl.ld2)
            begin
                v1_reg <= 1'b0;
            end
            if (ctl.ld2)
            begin
                v2_reg <= 1'b1;
            end
            else if (ctl.ld3)
            begin
                v2_reg <= 1'b0;
            end
            if (ctl.ld3)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        assign raw[a] = s_axis_tdata[a*RAW_W +: RAW_W];

        mahic_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .slot  (slot_reg),
            .raw   (raw[a]),
            .field (field[a]),
            .bias  (bias[a])
        );
    end

    assign packed_res = {bias[2], bias[1], bias[0], field[2], field[1], field[0]};

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            out_data_reg <= mahic_pkg::OUT_DATA_W'(packed_res);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule : magnetometer_average_hard_iron_cal

`default_nettype wire

// ----- sv/mahic_div.sv -----
// ----------------------------------------------------------------------------
// mahic_div
// Divides a window-sum magnitude by WINDOW through a registered multiply
// by a rounded-up reciprocal; the quotient is exact for every magnitude
// the sum can reach.
// ----------------------------------------------------------------------------
`default_nettype none

module mahic_div #(
    parameter int WINDOW = mahic_pkg::DEF_WINDOW
) (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire logic [mahic_pkg::RAW_W+$clog2(WINDOW)-1:0] mag,
    output logic      [mahic_pkg::QUO_W-1:0]         quo
);

    localparam int L_W   = $clog2(WINDOW);
    localparam int MAG_W = mahic_pkg::RAW_W + L_W;
    localparam int SH    = MAG_W + L_W;
    localparam int M_W   = MAG_W + 2;
    localparam int P_W   = MAG_W + M_W;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= P_W'(mag) * P_W'(RECIP);
        end
    end

    assign quo = prod_reg[SH +: mahic_pkg::QUO_W];

endmodule : mahic_div

`default_nettype wire

// ----- sv/mahic_lane.sv -----
// ----------------------------------------------------------------------------
// mahic_lane
// One axis: sample ring with running sum, calibration min/max and offset,
// division by the window length, and the offset-corrected field.
// ----------------------------------------------------------------------------
`default_nettype none

module mahic_lane #(
    parameter int WINDOW = mahic_pkg::DEF_WINDOW
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire mahic_pkg::lane_ctl_t                 ctl,
    input  wire logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] slot,
    input  wire logic signed [mahic_pkg::RAW_W-1:0]   raw,
    output logic signed [mahic_pkg::FIELD_W-1:0]      field,
    output logic signed [mahic_pkg::RAW_W-1:0]        bias
);

    localparam int RAW_W   = mahic_pkg::RAW_W;
    localparam int FIELD_W = mahic_pkg::FIELD_W;
    localparam int QUO_W   = mahic_pkg::QUO_W;
    localparam int L_W     = $clog2(WINDOW);
    localparam int SUM_W   = RAW_W + L_W;
    localparam int ACC_W   = FIELD_W + 1;

    logic signed [RAW_W-1:0] ring_reg [WINDOW];
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [RAW_W-1:0] min_reg;
    logic signed [RAW_W-1:0] max_reg;
    logic signed [RAW_W-1:0] off_reg;
    logic signed [FIELD_W-1:0] last_field_reg;

    logic signed [SUM_W-1:0] sum_next;
    logic signed [RAW_W-1:0] min_next;
    logic signed [RAW_W-1:0] max_next;
    logic signed [RAW_W-1:0] off_next;
    logic signed [RAW_W:0]   mid_sum;
    logic signed [RAW_W:0]   mid_half;

    // Stage 1 and stage 2 payload.
    logic [SUM_W-1:0]        mag1_reg;
    logic                    neg1_reg;
    logic                    meas1_reg;
    logic signed [RAW_W-1:0] off1_reg;
    logic                    neg2_reg;
    logic                    meas2_reg;
    logic signed [RAW_W-1:0] off2_reg;

    logic [QUO_W-1:0]        quo;
    logic signed [ACC_W-1:0] avg;
    logic signed [ACC_W-1:0] diff;
    logic signed [FIELD_W-1:0] field_calc;

    // The running sum drops the entry about to be overwritten.
    assign sum_next = sum_reg - SUM_W'(ring_reg[slot]) + SUM_W'(raw);

    // Midpoint truncated toward zero: add one before the shift when negative.
    assign mid_sum  = (RAW_W+1)'(max_reg) + (RAW_W+1)'(min_reg);
    assign mid_half = (mid_sum + (RAW_W+1)'(mid_sum < 0)) >>> 1;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        off_next = off_reg;
        unique case (ctl.cmd)
            mahic_pkg::CMD_MEASURE:
            begin
            end
            mahic_pkg::CMD_CAL_BEGIN:
            begin
                min_next = mahic_pkg::CAL_MIN_START;
                max_next = mahic_pkg::CAL_MAX_START;
                off_next = '0;
            end
            mahic_pkg::CMD_CAL_SAMPLE:
            begin
                if (min_reg > raw)
                begin
                    min_next = raw;
                end
                if (max_reg < raw)
                begin
                    max_next = raw;
                end
            end
            mahic_pkg::CMD_CAL_END:
            begin
                off_next = mid_half[RAW_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg        <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            off_reg        <= '0;
            last_field_reg <= '0;
        end
        else
        begin
            if (ctl.ld1)
            begin
                if (ctl.cmd == mahic_pkg::CMD_MEASURE)
                begin
                    ring_reg[slot] <= raw;
                    sum_reg        <= sum_next;
                end
                min_reg <= min_next;
                max_reg <= max_next;
                off_reg <= off_next;
            end
            if (ctl.ld3 && meas2_reg)
            begin
                last_field_reg <= field_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            mag1_reg  <= (sum_next < 0) ? SUM_W'(-sum_next) : SUM_W'(sum_next);
            neg1_reg  <= (sum_next < 0);
            meas1_reg <= (ctl.cmd == mahic_pkg::CMD_MEASURE);
            off1_reg  <= off_next;
        end
        if (ctl.ld2)
        begin
            neg2_reg  <= neg1_reg;
            meas2_reg <= meas1_reg;
            off2_reg  <= off1_reg;
        end
    end

    mahic_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .clk  (clk),
        .load (ctl.ld2),
        .mag  (mag1_reg),
        .quo  (quo)
    );

    assign avg        = neg2_reg ? -ACC_W'(quo) : ACC_W'(quo);
    assign diff       = avg - ACC_W'(off2_reg);
    assign field_calc = diff[FIELD_W-1:0];

    assign field = meas2_reg ? field_calc : last_field_reg;
    assign bias  = off2_reg;

endmodule : mahic_lane

`default_nettype wire
